### rtl/lct_pkg.sv
package lct_pkg;
  localparam int ENTRIES = 16;
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int QD = 2;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    FN_GET   = 2'd0,
    FN_PUT   = 2'd1,
    FN_SWEEP = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] key;
    logic [31:0] value;
    logic [47:0] expiry;
    logic [47:0] now_ms;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EVICT,
    ST_INSERT,
    ST_SWEEP,
    ST_DONE
  } state_t;
endpackage

### rtl/lct_front.sv
module lct_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [31:0]        in_key,
  input  logic [31:0]        in_value,
  input  logic [30:0]        in_ttl_ms,
  input  logic [47:0]        in_now_ms,
  output logic               q_valid,
  output lct_pkg::req_t      q_req,
  input  logic               q_pop
);
  import lct_pkg::*;

  req_t            mem_r [QD];
  logic            wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [48:0]     sum;
  req_t            req;
  logic            push;

  assign sum = {1'b0, in_now_ms} + {18'd0, in_ttl_ms};
  always_comb begin
    req.func   = func_t'(in_func);
    req.key    = in_key;
    req.value  = in_value;
    req.expiry = sum[48] ? TIME_MAX : sum[47:0];
    req.now_ms = in_now_ms;
  end

  assign in_stall = (cnt_r == 2'(QD));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= req;
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'(QD) |-> !push) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0) else $error("queue underflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QD)) else $error("count out of range");
endmodule

### rtl/lct_back.sv
module lct_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [4:0]         capacity,
  input  logic               q_valid,
  input  lct_pkg::req_t      q_req,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [31:0]        out_read_value,
  output logic [4:0]         out_evicted_count
);
  import lct_pkg::*;

  logic [31:0]   key_r   [ENTRIES];
  logic [31:0]   val_r   [ENTRIES];
  logic [47:0]   exp_r   [ENTRIES];
  logic [IW-1:0] rank_r  [ENTRIES];
  logic [IW-1:0] rank_nxt[ENTRIES];
  logic [ENTRIES-1:0] vld_r, vld_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  state_t        st_r, st_nxt;
  req_t          req_r;
  logic          hitf_r, hitf_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          ov_r, ov_nxt;
  logic          oh_r, oh_nxt;
  logic [31:0]   orv_r, orv_nxt;
  logic [4:0]    oev_r, oev_nxt;
  logic [CW-1:0] cap;
  logic          m_hit, o_fnd, f_fnd;
  logic [IW-1:0] m_idx, o_idx, f_idx;
  logic          wr_en;
  logic          take;

  assign cap = (capacity > 5'(ENTRIES)) ? CW'(ENTRIES) : CW'(capacity);
  assign take = q_valid && st_r == ST_IDLE && (!ov_r || !out_stall);
  assign q_pop = take;

  always_comb begin
    m_hit = 1'b0; m_idx = '0; o_fnd = 1'b0; o_idx = '0; f_fnd = 1'b0; f_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (vld_r[i] && key_r[i] == req_r.key) begin m_hit = 1'b1; m_idx = IW'(i); end
      if (vld_r[i] && CW'(rank_r[i]) == occ_r - CW'(1)) begin
        o_fnd = 1'b1; o_idx = IW'(i);
      end
      if (!vld_r[i]) begin f_fnd = 1'b1; f_idx = IW'(i); end
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (take) st_nxt = ST_LOOK;
      ST_LOOK: begin
        priority case (req_r.func)
          FN_GET:   st_nxt = ST_DONE;
          FN_PUT:   st_nxt = (cap == '0) ? ST_DONE : (m_hit ? ST_DONE : ST_EVICT);
          FN_SWEEP: st_nxt = ST_SWEEP;
          default:  st_nxt = ST_DONE;
        endcase
      end
      ST_EVICT:  if (!(occ_r >= cap && o_fnd)) st_nxt = ST_INSERT;
      ST_INSERT: st_nxt = ST_DONE;
      ST_SWEEP:  if (!o_fnd || req_r.now_ms < exp_r[o_idx]) st_nxt = ST_DONE;
      ST_DONE:   st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    logic          drop, mk, ins;
    logic [IW-1:0] t;
    drop = 1'b0; mk = 1'b0; ins = 1'b0; t = '0;
    vld_nxt = vld_r; occ_nxt = occ_r; rank_nxt = rank_r;
    hitf_nxt = hitf_r; idx_nxt = idx_r; wr_en = 1'b0;
    ov_nxt = ov_r; oh_nxt = oh_r; orv_nxt = orv_r; oev_nxt = oev_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (take) begin oh_nxt = 1'b0; orv_nxt = '1; oev_nxt = '0; end
      end
      ST_LOOK: begin
        hitf_nxt = m_hit; idx_nxt = m_idx; t = m_idx;
        if (req_r.func == FN_GET && m_hit) begin
          if (req_r.now_ms >= exp_r[m_idx]) begin drop = 1'b1; oev_nxt = 5'd1; end
          else begin mk = 1'b1; oh_nxt = 1'b1; orv_nxt = val_r[m_idx]; end
        end else if (req_r.func == FN_PUT && cap != '0 && m_hit) begin
          mk = 1'b1; wr_en = 1'b1;
        end
      end
      ST_EVICT: begin
        t = o_idx;
        if (occ_r >= cap && o_fnd) begin drop = 1'b1; oev_nxt = oev_r + 5'd1; end
      end
      ST_INSERT: begin
        if (f_fnd) begin ins = 1'b1; idx_nxt = f_idx; wr_en = 1'b1; end
      end
      ST_SWEEP: begin
        t = o_idx;
        if (o_fnd && req_r.now_ms >= exp_r[o_idx]) begin
          drop = 1'b1; oev_nxt = oev_r + 5'd1;
        end
      end
      ST_DONE: ov_nxt = 1'b1;
      default: ;
    endcase
    for (int j = 0; j < ENTRIES; j++) begin
      if (drop && vld_r[j] && rank_r[j] > rank_r[t]) rank_nxt[j] = rank_r[j] - IW'(1);
      if (mk && vld_r[j] && rank_r[j] < rank_r[t]) rank_nxt[j] = rank_r[j] + IW'(1);
      if (ins && vld_r[j]) rank_nxt[j] = rank_r[j] + IW'(1);
    end
    if (drop) begin
      vld_nxt[t] = 1'b0; rank_nxt[t] = '0;
      if (occ_r != '0) occ_nxt = occ_r - CW'(1);
    end
    if (mk) rank_nxt[t] = '0;
    if (ins) begin
      vld_nxt[f_idx] = 1'b1; rank_nxt[f_idx] = '0; occ_nxt = occ_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; vld_r <= '0; occ_r <= '0; ov_r <= 1'b0;
      for (int j = 0; j < ENTRIES; j++) rank_r[j] <= '0;
    end else begin
      st_r <= st_nxt; vld_r <= vld_nxt; occ_r <= occ_nxt; ov_r <= ov_nxt;
      rank_r <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) req_r <= q_req;
    hitf_r <= hitf_nxt; idx_r <= idx_nxt;
    oh_r <= oh_nxt; orv_r <= orv_nxt; oev_r <= oev_nxt;
    if (wr_en) begin
      key_r[idx_nxt] <= req_r.key;
      val_r[idx_nxt] <= req_r.value;
      exp_r[idx_nxt] <= req_r.expiry;
    end
  end

  assign out_valid = ov_r;
  assign out_hit = oh_r;
  assign out_read_value = orv_r;
  assign out_evicted_count = oev_r;

  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    CW'($countones(vld_r)) == occ_r) else $error("occupancy mismatch");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |=> ov_r) else $error("result dropped");
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !oh_r |-> orv_r == '1) else $error("miss value");
  a_hitf: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_INSERT |-> !hitf_r) else $error("insert on hit");
endmodule

### rtl/lru_cache_with_ttl_top.sv
// Flow: get, put on an existing key or at capacity 0, and unused codes go lookup then done;
// a new-key put goes lookup, evict (held while capacity evictions remain), insert, done;
// a sweep stays in the sweep state while expired entries remain, then done. The back end
// takes the next request no earlier than the edge where the previous result leaves.
// A two-entry request queue decouples the input from the back end.
// Reset (rst_n, synchronous): clears valid bits, ranks, occupancy, queue; capacity becomes 16.
module lru_cache_with_ttl_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_capacity,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  input  logic [30:0] in_ttl_ms,
  input  logic [47:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [31:0] out_read_value,
  output logic [4:0]  out_evicted_count
);
  import lct_pkg::*;

  logic [4:0] cap_r;
  logic       q_valid, q_pop;
  req_t       q_req;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= 5'd16;
    else if (cfg_valid) cap_r <= cfg_capacity;
  end

  lct_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_func, .in_key, .in_value,
    .in_ttl_ms, .in_now_ms, .q_valid, .q_req, .q_pop
  );

  lct_back u_back (
    .clk, .rst_n, .capacity(cap_r), .q_valid, .q_req, .q_pop,
    .out_valid, .out_stall, .out_hit, .out_read_value, .out_evicted_count
  );
endmodule
